@@ hdl/voxel_height_band_max_slice_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the voxel height band max slice core
// Concurrent checks sampled on the rising clock edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef VOXEL_HEIGHT_BAND_MAX_SLICE_CORE_ASSERT_SVH
`define VOXEL_HEIGHT_BAND_MAX_SLICE_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define VHBM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define VHBM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/vhbm_pkg.sv @@
// ----------------------------------------------------------------------------
// vhbm_pkg
// Shared constants and types of the voxel height band max slice core.
// ----------------------------------------------------------------------------
package vhbm_pkg;

   localparam int VOX_W     = 8;
   localparam int DATA_W    = 32;
   localparam int DEN_W     = 31;
   localparam int REM_W     = DEN_W + 1;
   localparam int NUM_W     = 35;
   localparam int CSIZE_W   = 9;
   localparam int SZ_CMP_W  = 11;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_HEIGHT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_THICKNESS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_HEIGHT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SIZE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y         = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z         = 3'd6;

   localparam logic [DATA_W-1:0]  RST_CELL_SIZE = 32'd65536;
   localparam logic [CSIZE_W-1:0] RST_SIDE      = 9'd256;
   localparam logic [CSIZE_W-1:0] RST_LAYERS    = 9'd1;

   localparam logic signed [VOX_W-1:0] COL_EMPTY = -8'sd1;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   typedef struct packed {
      logic first_layer;
      logic in_band;
      logic emit;
      logic last_col;
   } item_ctl_type;

endpackage

@@ hdl/voxel_height_band_max_slice_core.sv @@
// ----------------------------------------------------------------------------
// voxel_height_band_max_slice_core
// Projects the maximum voxel of a height band of each map column.
// ----------------------------------------------------------------------------
// Voxels stream in x fastest, then y, then z, and the block takes one voxel
// per cycle, unless band setup or result back-pressure stalls it, through a
// read, update and write back of the column memory (MAX_SIDE*MAX_SIDE entries
// of 8 bits, registered read). At the first voxel of every map the layer band
// is worked out on one shared bit-serial divider: three divisions of 35 steps,
// during which that first voxel waits. Each column's maximum is returned while
// the top layer streams in, one result beat per voxel of that layer, in x-then-y
// order, with tlast on the last column. Sizes and band are latched at the first
// voxel of a map, so register writes take effect with the next map. The memory
// is never cleared: layer zero writes every column before it is read.
// ----------------------------------------------------------------------------
module voxel_height_band_max_slice_core #(
   parameter int MAX_SIDE   = 256,
   parameter int MAX_LAYERS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vhbm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vhbm_pkg::DATA_W-1:0]         csr_data,
   // voxel stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] voxel_value
   // column result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,   // [7:0] column_max
   output logic                                rsp_tlast    // slice_end
);

`include "voxel_height_band_max_slice_core_assert.svh"

   localparam int S_W   = $clog2(MAX_SIDE + 1);
   localparam int X_W   = $clog2(MAX_SIDE);
   localparam int Z_W   = $clog2(MAX_LAYERS + 1);
   localparam int ZP_W  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int A_W   = $clog2(DEPTH);
   localparam int CW    = vhbm_pkg::SZ_CMP_W;

   logic signed [vhbm_pkg::DATA_W-1:0] slice_height_ff;
   logic signed [vhbm_pkg::DATA_W-1:0] half_thickness_ff;
   logic signed [vhbm_pkg::DATA_W-1:0] origin_height_ff;
   logic [vhbm_pkg::DEN_W-1:0]         cell_size_ff;
   logic [vhbm_pkg::CSIZE_W-1:0]       size_x_ff;
   logic [vhbm_pkg::CSIZE_W-1:0]       size_y_ff;
   logic [vhbm_pkg::CSIZE_W-1:0]       size_z_ff;

   logic [S_W-1:0]  lat_x_ff;
   logic [S_W-1:0]  lat_y_ff;
   logic [Z_W-1:0]  lat_z_ff;
   logic [X_W-1:0]  pos_x_ff;
   logic [X_W-1:0]  pos_y_ff;
   logic [ZP_W-1:0] pos_z_ff;
   logic [A_W-1:0]  col_ff;
   logic            band_ok_ff;

   logic            rsp_valid_ff;
   logic [7:0]      rsp_data_ff;
   logic            rsp_last_ff;

   logic [X_W-1:0]  pos_x_in;
   logic [X_W-1:0]  pos_y_in;
   logic [ZP_W-1:0] pos_z_in;
   logic [A_W-1:0]  col_in;

   logic [S_W-1:0]  side_x;
   logic [S_W-1:0]  side_y;
   logic [Z_W-1:0]  layers;
   logic            map_start;
   logic            end_x;
   logic            end_y;
   logic            end_z;
   logic            accept;
   logic            out_free;
   logic            s1_move;
   logic            band_start;

   vhbm_pkg::unit_stat_type           band_stat;
   logic [ZP_W-1:0]                   band_low;
   logic [Z_W-1:0]                    band_high;
   vhbm_pkg::item_ctl_type            item_ctl;
   logic                              s1_valid;
   vhbm_pkg::item_ctl_type            s1_ctl;
   logic signed [vhbm_pkg::VOX_W-1:0] cur;

   function automatic logic [CW-1:0] clamp_size(input logic [vhbm_pkg::CSIZE_W-1:0] v,
                                                input logic [CW-1:0] maxv);
      logic [CW-1:0] ext;
      ext = CW'(v);
      if (ext == '0) begin
         return CW'(1);
      end else if (ext > maxv) begin
         return maxv;
      end
      return ext;
   endfunction

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_height_ff   <= '0;
         half_thickness_ff <= '0;
         origin_height_ff  <= '0;
         cell_size_ff      <= vhbm_pkg::RST_CELL_SIZE[vhbm_pkg::DEN_W-1:0];
         size_x_ff         <= vhbm_pkg::RST_SIDE;
         size_y_ff         <= vhbm_pkg::RST_SIDE;
         size_z_ff         <= vhbm_pkg::RST_LAYERS;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            vhbm_pkg::CSR_SLICE_HEIGHT:   slice_height_ff   <= csr_data;
            vhbm_pkg::CSR_HALF_THICKNESS: half_thickness_ff <= csr_data;
            vhbm_pkg::CSR_ORIGIN_HEIGHT:  origin_height_ff  <= csr_data;
            vhbm_pkg::CSR_CELL_SIZE:      cell_size_ff <= csr_data[vhbm_pkg::DEN_W-1:0];
            vhbm_pkg::CSR_SIZE_X:         size_x_ff <= csr_data[vhbm_pkg::CSIZE_W-1:0];
            vhbm_pkg::CSR_SIZE_Y:         size_y_ff <= csr_data[vhbm_pkg::CSIZE_W-1:0];
            vhbm_pkg::CSR_SIZE_Z:         size_z_ff <= csr_data[vhbm_pkg::CSIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      side_x = S_W'(clamp_size(size_x_ff, CW'(MAX_SIDE)));
      side_y = S_W'(clamp_size(size_y_ff, CW'(MAX_SIDE)));
      layers = Z_W'(clamp_size(size_z_ff, CW'(MAX_LAYERS)));
   end

   vhbm_band #(
      .MAX_LAYERS (MAX_LAYERS)
   ) u_band (
      .clock          (clock),
      .reset          (reset),
      .start          (band_start),
      .slice_height   (slice_height_ff),
      .half_thickness (half_thickness_ff),
      .origin_height  (origin_height_ff),
      .cell_size      (cell_size_ff),
      .layers         (layers),
      .stat           (band_stat),
      .band_low       (band_low),
      .band_high      (band_high)
   );

   // position and handshake
   always_comb begin
      map_start  = (pos_x_ff == '0) && (pos_y_ff == '0) && (pos_z_ff == '0);
      end_x      = (S_W'(pos_x_ff) == lat_x_ff - S_W'(1));
      end_y      = (S_W'(pos_y_ff) == lat_y_ff - S_W'(1));
      end_z      = (Z_W'(pos_z_ff) == lat_z_ff - Z_W'(1));
      out_free   = !rsp_valid_ff || rsp_tready;
      s1_move    = s1_valid && (!s1_ctl.emit || out_free);
      req_tready = (!map_start || band_ok_ff) && (!s1_valid || s1_move);
      accept     = req_tvalid && req_tready;
      band_start = map_start && !band_ok_ff && req_tvalid &&
                   !band_stat.busy && !band_stat.done;

      item_ctl.first_layer = (pos_z_ff == '0);
      item_ctl.in_band     = (pos_z_ff >= band_low) && (Z_W'(pos_z_ff) < band_high);
      item_ctl.emit        = end_z;
      item_ctl.last_col    = end_x && end_y;

      pos_x_in = end_x ? '0 : pos_x_ff + X_W'(1);
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      col_in   = (end_x && end_y) ? '0 : col_ff + A_W'(1);
      if (end_x) begin
         pos_y_in = end_y ? '0 : pos_y_ff + X_W'(1);
         if (end_y) begin
            pos_z_in = end_z ? '0 : pos_z_ff + ZP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         pos_z_ff   <= '0;
         col_ff     <= '0;
         lat_x_ff   <= S_W'(1);
         lat_y_ff   <= S_W'(1);
         lat_z_ff   <= Z_W'(1);
         band_ok_ff <= 1'b0;
      end else begin
         if (band_stat.done) begin
            lat_x_ff   <= side_x;
            lat_y_ff   <= side_y;
            lat_z_ff   <= layers;
            band_ok_ff <= 1'b1;
         end
         if (accept) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
            pos_z_ff <= pos_z_in;
            col_ff   <= col_in;
            if (end_x && end_y && end_z) begin
               band_ok_ff <= 1'b0;
            end
         end
      end
   end

   vhbm_col_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .addr     (col_ff),
      .vox      ($signed(req_tdata)),
      .ctl      (item_ctl),
      .s1_move  (s1_move),
      .s1_valid (s1_valid),
      .s1_ctl   (s1_ctl),
      .cur      (cur)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move && s1_ctl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_ctl.emit) begin
         rsp_data_ff <= cur;
         rsp_last_ff <= s1_ctl.last_col;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `VHBM_ASSERT_NOW(a_no_take_in_setup, clock, reset, band_stat.busy, !req_tready, "voxel taken during band setup")
   `VHBM_ASSERT_NOW(a_band_before_map, clock, reset, accept && map_start, band_ok_ff, "map started without band")
   `VHBM_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_tready, !(s1_move && s1_ctl.emit), "pending result overwritten")
   `VHBM_ASSERT_NEXT(a_emit_lands, clock, reset, s1_move && s1_ctl.emit, rsp_valid_ff, "column result lost")

endmodule

@@ hdl/vhbm_div.sv @@
// ----------------------------------------------------------------------------
// vhbm_div
// Signed by positive restoring divider, one quotient bit per cycle, quotient
// and remainder truncated toward zero.
// ----------------------------------------------------------------------------
module vhbm_div (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic signed [vhbm_pkg::NUM_W-1:0]       num,
   input  logic        [vhbm_pkg::DEN_W-1:0]       den,
   output vhbm_pkg::unit_stat_type                 stat,
   output logic signed [vhbm_pkg::NUM_W-1:0]       quo,
   output logic signed [vhbm_pkg::REM_W-1:0]       rem
);

   localparam int CNT_W = $clog2(vhbm_pkg::NUM_W + 1);

   logic                             busy_ff;
   logic                             done_ff;
   logic [CNT_W-1:0]                 cnt_ff;
   logic                             neg_ff;
   logic [vhbm_pkg::NUM_W-1:0]       quo_ff;
   logic [vhbm_pkg::REM_W-1:0]       rem_ff;

   logic [vhbm_pkg::NUM_W-1:0]       num_mag;
   logic [vhbm_pkg::REM_W-1:0]       trial;
   logic                             fits;
   logic [vhbm_pkg::REM_W-1:0]       rem_in;
   logic [vhbm_pkg::NUM_W-1:0]       quo_in;

   always_comb begin
      num_mag = num[vhbm_pkg::NUM_W-1] ? vhbm_pkg::NUM_W'(-num) : vhbm_pkg::NUM_W'(num);
      trial   = {rem_ff[vhbm_pkg::DEN_W-1:0], quo_ff[vhbm_pkg::NUM_W-1]};
      fits    = trial >= {1'b0, den};
      rem_in  = fits ? trial - {1'b0, den} : trial;
      quo_in  = {quo_ff[vhbm_pkg::NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(vhbm_pkg::NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= num[vhbm_pkg::NUM_W-1];
         quo_ff <= num_mag;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
   assign rem = neg_ff ? -$signed(rem_ff) : $signed(rem_ff);

endmodule

@@ hdl/vhbm_band.sv @@
// ----------------------------------------------------------------------------
// vhbm_band
// Layer band setup: three divisions on the shared divider; the low and high
// layer bounds are clamped to the map height as their divisions finish.
// ----------------------------------------------------------------------------
module vhbm_band #(
   parameter int MAX_LAYERS = 256
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   input  logic signed [vhbm_pkg::DATA_W-1:0]            slice_height,
   input  logic signed [vhbm_pkg::DATA_W-1:0]            half_thickness,
   input  logic signed [vhbm_pkg::DATA_W-1:0]            origin_height,
   input  logic        [vhbm_pkg::DEN_W-1:0]             cell_size,
   input  logic        [$clog2(MAX_LAYERS+1)-1:0]        layers,
   output vhbm_pkg::unit_stat_type                       stat,
   output logic [((MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1)-1:0] band_low,
   output logic [$clog2(MAX_LAYERS+1)-1:0]               band_high
);

   localparam int Z_W  = $clog2(MAX_LAYERS + 1);
   localparam int ZP_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int NW   = vhbm_pkg::NUM_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_HALF = 2'd1;
   localparam logic [1:0] ST_LOW  = 2'd2;
   localparam logic [1:0] ST_HIGH = 2'd3;

   logic [1:0]                      state_ff;
   logic                            done_ff;
   logic                            div_start_ff;
   logic signed [NW-1:0]            div_num_ff;
   logic signed [vhbm_pkg::DATA_W:0] hmr_ff;
   logic [ZP_W-1:0]                 band_low_ff;
   logic [Z_W-1:0]                  band_high_ff;

   logic [vhbm_pkg::DEN_W-1:0]      res;
   logic signed [vhbm_pkg::DATA_W:0] height_diff;
   logic signed [vhbm_pkg::DATA_W:0] hmr_in;
   logic signed [NW-1:0]            low_num;
   logic signed [NW-1:0]            high_num;
   logic signed [NW-1:0]            zlim;
   logic signed [NW-1:0]            zlim_m1;
   logic [ZP_W-1:0]                 low_in;
   logic [Z_W-1:0]                  high_in;

   vhbm_pkg::unit_stat_type         div_stat;
   logic signed [NW-1:0]            div_quo;
   logic signed [vhbm_pkg::REM_W-1:0] div_rem;

   vhbm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num_ff),
      .den   (res),
      .stat  (div_stat),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   always_comb begin
      res         = (cell_size == '0) ? vhbm_pkg::DEN_W'(1) : cell_size;
      height_diff = (vhbm_pkg::DATA_W+1)'(slice_height)
                    - (vhbm_pkg::DATA_W+1)'(origin_height);
      hmr_in      = (vhbm_pkg::DATA_W+1)'(half_thickness) - (vhbm_pkg::DATA_W+1)'(div_rem);
      low_num     = NW'(height_diff) - NW'(hmr_in);
      high_num    = NW'(height_diff) + NW'(hmr_ff) + $signed(NW'(res));
      zlim        = $signed(NW'(layers));
      zlim_m1     = zlim - NW'(1);
      if (div_quo < 0) begin
         low_in = '0;
      end else if (div_quo > zlim_m1) begin
         low_in = ZP_W'(zlim_m1);
      end else begin
         low_in = ZP_W'(div_quo);
      end
      if (div_quo < NW'(1)) begin
         high_in = Z_W'(1);
      end else if (div_quo > zlim) begin
         high_in = layers;
      end else begin
         high_in = Z_W'(div_quo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         done_ff      <= 1'b0;
         div_start_ff <= 1'b0;
         band_low_ff  <= '0;
         band_high_ff <= Z_W'(1);
      end else begin
         done_ff      <= 1'b0;
         div_start_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_HALF;
               end
            end
            ST_HALF: begin
               if (div_stat.done) begin
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_LOW;
               end
            end
            ST_LOW: begin
               if (div_stat.done) begin
                  band_low_ff  <= low_in;
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_HIGH;
               end
            end
            ST_HIGH: begin
               if (div_stat.done) begin
                  band_high_ff <= high_in;
                  done_ff      <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         div_num_ff <= NW'(half_thickness);
      end else if (state_ff == ST_HALF && div_stat.done) begin
         hmr_ff     <= hmr_in;
         div_num_ff <= low_num;
      end else if (state_ff == ST_LOW && div_stat.done) begin
         div_num_ff <= high_num;
      end
   end

   assign stat.busy = (state_ff != ST_IDLE);
   assign stat.done = done_ff;
   assign band_low  = band_low_ff;
   assign band_high = band_high_ff;

endmodule

@@ hdl/vhbm_col_store.sv @@
// ----------------------------------------------------------------------------
// vhbm_col_store
// Column maximum memory with read, update and write back of one voxel per
// cycle; forwards the previous write when consecutive voxels hit one column.
// ----------------------------------------------------------------------------
module vhbm_col_store #(
   parameter int DEPTH = 65536
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [$clog2(DEPTH)-1:0]             addr,
   input  logic signed [vhbm_pkg::VOX_W-1:0]    vox,
   input  vhbm_pkg::item_ctl_type               ctl,
   input  logic                                 s1_move,
   output logic                                 s1_valid,
   output vhbm_pkg::item_ctl_type               s1_ctl,
   output logic signed [vhbm_pkg::VOX_W-1:0]    cur
);

   localparam int A_W = $clog2(DEPTH);

   logic signed [vhbm_pkg::VOX_W-1:0] mem [DEPTH];

   logic                               s1_valid_ff;
   logic [A_W-1:0]                     s1_addr_ff;
   logic signed [vhbm_pkg::VOX_W-1:0]  s1_vox_ff;
   vhbm_pkg::item_ctl_type             s1_ctl_ff;
   logic signed [vhbm_pkg::VOX_W-1:0]  rd_data_ff;
   logic                               fwd_sel_ff;
   logic signed [vhbm_pkg::VOX_W-1:0]  fwd_val_ff;

   logic signed [vhbm_pkg::VOX_W-1:0]  old_val;
   logic signed [vhbm_pkg::VOX_W-1:0]  base_val;
   logic signed [vhbm_pkg::VOX_W-1:0]  cur_in;

   always_comb begin
      old_val  = fwd_sel_ff ? fwd_val_ff : rd_data_ff;
      base_val = s1_ctl_ff.first_layer ? vhbm_pkg::COL_EMPTY : old_val;
      cur_in   = (s1_ctl_ff.in_band && (s1_vox_ff > base_val)) ? s1_vox_ff : base_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= mem[addr];
         s1_addr_ff <= addr;
         s1_vox_ff  <= vox;
         s1_ctl_ff  <= ctl;
         fwd_sel_ff <= s1_valid_ff && s1_move && (s1_addr_ff == addr);
         fwd_val_ff <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_move) begin
         mem[s1_addr_ff] <= cur_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_ctl   = s1_ctl_ff;
   assign cur      = cur_in;

endmodule
